/* src/cvg_pkg.sv */
// Shared types, constants and helper functions for the capsule vertex generator.
`timescale 1ns / 1ps
package cvg_pkg;

   // Default parameter values.
   localparam int FRAC_BITS_DEF     = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   // CORDIC core format: 30 fraction bits, 34-bit signed datapath.
   localparam int ANG_TAB_LEN = 24;
   localparam int CORE_FRAC   = 30;
   localparam int CW          = 34;
   localparam logic signed [CW-1:0] CORE_GAIN = 34'sd652032874;

   // Divider: 32 quotient bits, remainder below the divisor (at most 511).
   localparam int DIV_STEPS = 32;
   localparam int REM_W     = 9;

   // atan(2^-i) as a binary angle, full turn = 2^32.
   localparam logic [31:0] ANG_TAB [ANG_TAB_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_WIDTH_X  = 3'd3,
      CSR_WIDTH_Y  = 3'd4,
      CSR_WIDTH_Z  = 3'd5,
      CSR_RINGS    = 3'd6,
      CSR_POINTS   = 3'd7
   } csr_index_type;

   // Request modes.
   typedef enum logic [1:0] {
      MODE_RING = 2'd0,
      MODE_TOP  = 2'd1,
      MODE_BOT  = 2'd2,
      MODE_BAD  = 2'd3
   } mode_type;

   // Per-item control that travels alongside the data.
   typedef struct packed {
      logic valid;
      logic err;
      logic pole_top;
      logic pole_bot;
      logic top;
   } ctrl_type;

   // One divider lane: partial remainder and the numerator/quotient shift word.
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [31:0]      nq;
   } div_lane_type;

   typedef struct packed {
      div_lane_type a;
      div_lane_type t;
   } div_data_type;

   // One CORDIC lane: vector, residual angle and the quadrant taken out.
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic [1:0]           q;
   } cordic_lane_type;

   typedef struct packed {
      cordic_lane_type a;
      cordic_lane_type t;
   } cordic_data_type;

   // Saturate a 36-bit signed sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* src/cvg_div_cell.sv */
// One restoring-division cell: retires one quotient bit for both angle lanes.
`timescale 1ns / 1ps
module cvg_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic [8:0]            divisor_a,
   input  logic [8:0]            divisor_t,
   input  cvg_pkg::ctrl_type     ctrl_in,
   input  cvg_pkg::div_data_type data_in,
   output cvg_pkg::ctrl_type     ctrl_out,
   output cvg_pkg::div_data_type data_out
);
   import cvg_pkg::*;

   ctrl_type     ctrl_ff;
   div_data_type data_ff;
   div_data_type data_in_next;

   // Shift in the next numerator bit, subtract the divisor when it fits.
   function automatic div_lane_type step(input div_lane_type l, input logic [8:0] d);
      div_lane_type     r;
      logic [REM_W:0]   rem2;
      logic             ge;
      rem2 = {l.rem, l.nq[31]};
      ge   = (rem2 >= {1'b0, d});
      if (ge) begin
         rem2 = rem2 - {1'b0, d};
      end
      r.rem = rem2[REM_W-1:0];
      r.nq  = {l.nq[30:0], ge};
      return r;
   endfunction

   always_comb begin
      data_in_next.a = step(data_in.a, divisor_a);
      data_in_next.t = step(data_in.t, divisor_t);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in_next;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign data_out = data_ff;

endmodule

/* src/cvg_cordic_cell.sv */
// One CORDIC rotation cell: a fixed shift and angle for both angle lanes.
`timescale 1ns / 1ps
module cvg_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  cvg_pkg::ctrl_type        ctrl_in,
   input  cvg_pkg::cordic_data_type data_in,
   output cvg_pkg::ctrl_type        ctrl_out,
   output cvg_pkg::cordic_data_type data_out
);
   import cvg_pkg::*;

   localparam logic signed [CW-1:0] ANG = $signed({2'b00, ANG_TAB[STAGE]});

   ctrl_type        ctrl_ff;
   cordic_data_type data_ff;
   cordic_data_type data_in_next;

   // Rotate toward zero residual angle.
   function automatic cordic_lane_type rot(input cordic_lane_type l);
      cordic_lane_type r;
      r.q = l.q;
      if (!l.z[CW-1]) begin
         r.x = l.x - (l.y >>> STAGE);
         r.y = l.y + (l.x >>> STAGE);
         r.z = l.z - ANG;
      end else begin
         r.x = l.x + (l.y >>> STAGE);
         r.y = l.y - (l.x >>> STAGE);
         r.z = l.z + ANG;
      end
      return r;
   endfunction

   always_comb begin
      data_in_next.a = rot(data_in.a);
      data_in_next.t = rot(data_in.t);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in_next;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign data_out = data_ff;

endmodule

/* src/cvg_out_stage.sv */
// Output pipeline: rounding, quadrant fold, radius and offset products, final sums.
`timescale 1ns / 1ps
module cvg_out_stage #(
   parameter int FRAC_BITS = cvg_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic signed [31:0]       center_x,
   input  logic signed [31:0]       center_y,
   input  logic signed [31:0]       center_z,
   input  logic [30:0]              width_x,
   input  logic [30:0]              width_y,
   input  logic [30:0]              width_z,
   input  cvg_pkg::ctrl_type        ctrl_in,
   input  cvg_pkg::cordic_data_type data_in,
   output logic                     out_valid,
   output logic signed [31:0]       vertex_x,
   output logic signed [31:0]       vertex_y,
   output logic signed [31:0]       vertex_z,
   output logic                     index_error
);
   import cvg_pkg::*;

   localparam int TW = FRAC_BITS + 3;   // trig value width
   localparam int PW = TW + 32;         // width times trig product
   localparam int RW = 33;              // radius width
   localparam int YW = FRAC_BITS + 37;  // y offset sum width
   localparam int MW = RW + TW;         // radius times trig product
   localparam int SH = CORE_FRAC - FRAC_BITS;

   ctrl_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff;

   // Stage 1: round CORDIC outputs and fold the quadrant back in.
   function automatic logic signed [TW-1:0] rnd_core(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] s;
      s = (v + (CW'(1) <<< (SH - 1))) >>> SH;
      return s[TW-1:0];
   endfunction

   logic signed [TW-1:0] xa, ya, xt, yt;
   logic signed [TW-1:0] ca, sa, ct, st;
   logic signed [TW-1:0] rs_in, hs_in;
   logic signed [TW-1:0] rs1_ff, hs1_ff, ct1_ff, st1_ff;

   always_comb begin
      xa = rnd_core(data_in.a.x);
      ya = rnd_core(data_in.a.y);
      xt = rnd_core(data_in.t.x);
      yt = rnd_core(data_in.t.y);
      case (data_in.a.q)
         2'd0:    begin ca = xa;  sa = ya;  end
         2'd1:    begin ca = -ya; sa = xa;  end
         2'd2:    begin ca = -xa; sa = -ya; end
         default: begin ca = ya;  sa = -xa; end
      endcase
      case (data_in.t.q)
         2'd0:    begin ct = xt;  st = yt;  end
         2'd1:    begin ct = -yt; st = xt;  end
         2'd2:    begin ct = -xt; st = -yt; end
         default: begin ct = yt;  st = -xt; end
      endcase
      // Bottom rings swap sine and cosine.
      rs_in = ctrl_in.top ? sa : ca;
      hs_in = ctrl_in.top ? ca : sa;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rs1_ff <= rs_in;
         hs1_ff <= hs_in;
         ct1_ff <= ct;
         st1_ff <= st;
      end
   end

   // Stage 2: widths times the ring sine and cosine.
   logic signed [PW-1:0] px2_ff, pz2_ff, py2_ff;
   logic signed [TW-1:0] ct2_ff, st2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px2_ff <= PW'($signed({1'b0, width_x})) * PW'(rs1_ff);
         pz2_ff <= PW'($signed({1'b0, width_z})) * PW'(rs1_ff);
         py2_ff <= PW'($signed({1'b0, width_x})) * PW'(hs1_ff);
         ct2_ff <= ct1_ff;
         st2_ff <= st1_ff;
      end
   end

   // Stage 3: radii and the y offset, rounded half up.
   logic signed [31:0]   wdiff;
   logic signed [YW-1:0] ysum;
   logic signed [RW-1:0] radx3_ff, radz3_ff;
   logic signed [33:0]   yoff3_ff;
   logic signed [TW-1:0] ct3_ff, st3_ff;

   always_comb begin
      wdiff = $signed({1'b0, width_y}) - $signed({1'b0, width_x});
      ysum  = (YW'(wdiff) <<< FRAC_BITS) + YW'(py2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         radx3_ff <= RW'((px2_ff + (PW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1));
         radz3_ff <= RW'((pz2_ff + (PW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1));
         yoff3_ff <= 34'((ysum + (YW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1));
         ct3_ff   <= ct2_ff;
         st3_ff   <= st2_ff;
      end
   end

   // Stage 4: radii times the angle cosine and sine.
   logic signed [MW-1:0] mx4_ff, mz4_ff;
   logic signed [33:0]   yoff4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mx4_ff   <= MW'(radx3_ff) * MW'(ct3_ff);
         mz4_ff   <= MW'(radz3_ff) * MW'(st3_ff);
         yoff4_ff <= yoff3_ff;
      end
   end

   // Stage 5: add the center, handle poles and bad indexes, saturate.
   logic signed [MW-1:0] mxr, mzr;
   logic signed [32:0]   ph;
   logic signed [35:0]   sx, sy, sz;
   logic signed [31:0]   vx_in, vy_in, vz_in;
   logic signed [31:0]   vx_ff, vy_ff, vz_ff;

   always_comb begin
      mxr = (mx4_ff + (MW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      mzr = (mz4_ff + (MW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (c4_ff.pole_top) begin
         ph = ($signed({2'b00, width_y}) + 33'sd1) >>> 1;
      end else begin
         ph = (-$signed({2'b00, width_y}) + 33'sd1) >>> 1;
      end
      sx = 36'(center_x);
      sy = 36'(center_y);
      sz = 36'(center_z);
      if (c4_ff.pole_top || c4_ff.pole_bot) begin
         sy = 36'(center_y) + 36'(ph);
      end else if (!c4_ff.err) begin
         sx = 36'(center_x) + 36'(mxr);
         sz = 36'(center_z) + 36'(mzr);
         if (c4_ff.top) begin
            sy = 36'(center_y) + 36'(yoff4_ff);
         end else begin
            sy = 36'(center_y) - 36'(yoff4_ff);
         end
      end
      vx_in = sat32(sx);
      vy_in = sat32(sy);
      vz_in = sat32(sz);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         vz_ff <= vz_in;
      end
   end

   // Control follows the data through all five stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
      end else if (en) begin
         c1_ff <= ctrl_in;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
         c5_ff <= c4_ff;
      end
   end

   assign out_valid   = c5_ff.valid;
   assign vertex_x    = vx_ff;
   assign vertex_y    = vy_ff;
   assign vertex_z    = vz_ff;
   assign index_error = c5_ff.err;

endmodule

/* src/capsule_vertex_generator_core.sv */
// Top level of the capsule vertex generator: config registers and the cell chain.
//
//  Channel  Signals                                 Direction
//  req      req_tvalid/tready, tdata, tuser        in   (one vertex request per item)
//  rsp      rsp_tvalid/tready, tdata, tuser        out  (one vertex per item)
//  csr      csr_we, csr_addr, csr_wdata            in   (register writes, no read-back)
//
// One item enters per cycle while the chain is not held. The chain has an input
// register, 32 divider cells, a quadrant stage, the CORDIC cells and five output
// stages. Reset clears all valid flags and loads register defaults.
// The whole chain advances together and holds while a result waits on rsp_tready.
`timescale 1ns / 1ps
module capsule_vertex_generator_core #(
   parameter int FRAC_BITS     = cvg_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = cvg_pkg::CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // ring_index[5:0], point_index[13:6], zero pad
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // vertex_x[31:0], vertex_y[63:32], vertex_z[95:64]
   output logic        rsp_tuser,   // index_error
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);
   import cvg_pkg::*;

   localparam int NCS = (CORDIC_STAGES < ANG_TAB_LEN) ? CORDIC_STAGES : ANG_TAB_LEN;

   // Configuration registers.
   logic signed [31:0] center_x_ff, center_y_ff, center_z_ff;
   logic [30:0]        width_x_ff, width_y_ff, width_z_ff;
   logic [5:0]         rings_ff;
   logic [8:0]         points_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         width_x_ff  <= 31'd65536;
         width_y_ff  <= 31'd131072;
         width_z_ff  <= 31'd65536;
         rings_ff    <= 6'd9;
         points_ff   <= 9'd16;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_CENTER_Z: center_z_ff <= csr_wdata;
            CSR_WIDTH_X:  width_x_ff  <= csr_wdata[30:0];
            CSR_WIDTH_Y:  width_y_ff  <= csr_wdata[30:0];
            CSR_WIDTH_Z:  width_z_ff  <= csr_wdata[30:0];
            CSR_RINGS:    rings_ff    <= csr_wdata[5:0];
            CSR_POINTS:   points_ff   <= csr_wdata[8:0];
            default:      ;
         endcase
      end
   end

   // The chain moves whenever the output register is free or being drained.
   logic en;
   logic out_valid;
   assign en         = !out_valid || rsp_tready;
   assign req_tready = en;

   // Input stage: range checks and the divider numerators.
   logic [5:0]   half;
   logic [5:0]   ring, rr, num_a;
   logic [7:0]   point;
   mode_type     mode;
   logic         pole;
   ctrl_type     ctrl0_in;
   div_data_type data0_in;

   always_comb begin
      mode  = mode_type'(req_tuser);
      ring  = req_tdata[5:0];
      point = req_tdata[13:6];
      half  = 6'((7'(rings_ff) + 7'd1) >> 1);
      pole  = (mode == MODE_TOP) || (mode == MODE_BOT);
      ctrl0_in.valid    = req_tvalid;
      ctrl0_in.pole_top = (mode == MODE_TOP);
      ctrl0_in.pole_bot = (mode == MODE_BOT);
      ctrl0_in.err      = !pole && ((mode == MODE_BAD) || ({1'b0, ring} >= {half, 1'b0})
                                    || ({1'b0, point} >= points_ff));
      ctrl0_in.top      = ring < half;
      rr    = ctrl0_in.top ? ring : ring - half;
      num_a = rr + 6'd1;
      // Numerators are (rr+1)*2^30 and point*2^32; the bits above bit 31 seed the remainder.
      data0_in.a.rem = REM_W'(num_a >> 2);
      data0_in.a.nq  = {num_a[1:0], 30'd0};
      data0_in.t.rem = {1'b0, point};
      data0_in.t.nq  = '0;
   end

   ctrl_type     div_ctrl [DIV_STEPS+1];
   div_data_type div_data [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ctrl[0] <= '0;
      end else if (en) begin
         div_ctrl[0] <= ctrl0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_data[0] <= data0_in;
      end
   end

   // Divider cells: one quotient bit each for the ring and point angles.
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      cvg_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .divisor_a ({3'd0, half}),
         .divisor_t (points_ff),
         .ctrl_in   (div_ctrl[i]),
         .data_in   (div_data[i]),
         .ctrl_out  (div_ctrl[i+1]),
         .data_out  (div_data[i+1])
      );
   end

   // Quadrant stage: take out the nearest quarter turn, seed the CORDIC.
   function automatic cordic_lane_type seed(input logic [31:0] ang);
      cordic_lane_type l;
      logic [31:0]     sum;
      logic [31:0]     ru;
      sum  = ang + 32'h20000000;
      l.q  = sum[31:30];
      ru   = ang - {l.q, 30'd0};
      l.z  = CW'($signed(ru));
      l.x  = CORE_GAIN;
      l.y  = '0;
      return l;
   endfunction

   ctrl_type        cor_ctrl [NCS+1];
   cordic_data_type cor_data [NCS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cor_ctrl[0] <= '0;
      end else if (en) begin
         cor_ctrl[0] <= div_ctrl[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cor_data[0].a <= seed(div_data[DIV_STEPS].a.nq);
         cor_data[0].t <= seed(div_data[DIV_STEPS].t.nq);
      end
   end

   // CORDIC cells.
   for (genvar i = 0; i < NCS; i++) begin : g_cordic
      cvg_cordic_cell #(.STAGE(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctrl_in  (cor_ctrl[i]),
         .data_in  (cor_data[i]),
         .ctrl_out (cor_ctrl[i+1]),
         .data_out (cor_data[i+1])
      );
   end

   // Products, offsets and the output register.
   logic signed [31:0] vx, vy, vz;
   logic               ierr;

   cvg_out_stage #(.FRAC_BITS(FRAC_BITS)) u_out (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .center_z    (center_z_ff),
      .width_x     (width_x_ff),
      .width_y     (width_y_ff),
      .width_z     (width_z_ff),
      .ctrl_in     (cor_ctrl[NCS]),
      .data_in     (cor_data[NCS]),
      .out_valid   (out_valid),
      .vertex_x    (vx),
      .vertex_y    (vy),
      .vertex_z    (vz),
      .index_error (ierr)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {vz, vy, vx};
   assign rsp_tuser  = ierr;

endmodule

/* src/cvg_checker.sv */
// Port-level checks for the capsule vertex generator, bound to the top level.
`timescale 1ns / 1ps
module cvg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled result stays offered.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   // A stalled result keeps its value.
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // No result appears right after reset.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item offered after reset");

   // With the output register free, the block takes a new item.
   a_ready_free : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");

   // A draining output never blocks the input side.
   a_ready_drain : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |-> req_tready)
      else $error("request refused while result drains");

endmodule

bind capsule_vertex_generator_core cvg_checker u_cvg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
